### rtl/core/ile_pkg.sv
// Shared types and constants for the indexed list engine.
`default_nettype none

package ile_pkg;

  // Fixed field widths of the request and response transactions
  localparam int KIND_W = 3;
  localparam int POS_W  = 4;
  localparam int VAL_W  = 32;
  localparam int ST_W   = 2;
  localparam int FPOS_W = 4;
  localparam int CNT_W  = 5;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    K_APPEND = 3'd0,
    K_PUSH   = 3'd1,
    K_INSERT = 3'd2,
    K_POP    = 3'd3,
    K_DELETE = 3'd4,
    K_SEARCH = 3'd5
  } ile_kind_t;

  // Response status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ile_status_t;

  // Command broadcast from the controller to every cell
  typedef struct packed {
    logic ins;     // open a slot at pos, shift entries above it up
    logic del;     // close the slot at pos, shift entries above it down
    logic search;  // compare against value, seed the match wave
    logic scan;    // move the match wave one cell toward cell 0
  } ile_cmd_t;

endpackage

`default_nettype wire

### rtl/core/ile_ifs.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface ile_in_if;
  logic                       valid;
  logic                       ready;
  logic [ile_pkg::KIND_W-1:0] kind;
  logic [ile_pkg::POS_W-1:0]  position;
  logic signed [ile_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface ile_out_if;
  logic                       valid;
  logic                       ready;
  logic [ile_pkg::ST_W-1:0]   status;
  logic                       found;
  logic [ile_pkg::FPOS_W-1:0] found_position;
  logic [ile_pkg::CNT_W-1:0]  count;

  modport source (output valid, output status, output found, output found_position,
                  output count, input ready);
  modport sink   (input valid, input status, input found, input found_position,
                  input count, output ready);
endinterface

`default_nettype wire

### rtl/core/ile_cell.sv
// One list slot: holds an element, shifts with its neighbors, joins the match wave.
`default_nettype none

module ile_cell #(
  parameter int IDX        = 0,
  parameter int CW         = 5,
  parameter int IW         = 4,
  parameter int DATA_WIDTH = 32
) (
  input  wire                    clk,
  input  ile_pkg::ile_cmd_t      cmd,
  input  wire [CW-1:0]           pos,
  input  wire [CW-1:0]           count,
  input  wire [DATA_WIDTH-1:0]   value,
  input  wire [DATA_WIDTH-1:0]   left_elem,
  input  wire [DATA_WIDTH-1:0]   right_elem,
  input  wire                    right_found,
  input  wire [IW-1:0]           right_idx,
  output logic [DATA_WIDTH-1:0]  elem,
  output logic                   found,
  output logic [IW-1:0]          idx
);
  import ile_pkg::*;

  localparam logic [CW-1:0] MY_POS = CW'(IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [DATA_WIDTH-1:0] elem_r;
  logic                  hit_r;
  logic                  found_r;
  logic [IW-1:0]         idx_r;
  logic                  hit_nxt;

  // Match only on live entries
  assign hit_nxt = (elem_r == value) && (MY_POS < count);

  // Element storage: load, shift up on insert, shift down on delete
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_POS == pos) begin
        elem_r <= value;
      end else if (MY_POS > pos) begin
        elem_r <= left_elem;
      end
    end else if (cmd.del) begin
      if (MY_POS >= pos) begin
        elem_r <= right_elem;
      end
    end
  end

  // Match wave: a hit holds its own index, otherwise take the upper neighbor's
  always_ff @(posedge clk) begin
    if (cmd.search) begin
      hit_r   <= hit_nxt;
      found_r <= hit_nxt;
      idx_r   <= MY_IDX;
    end else if (cmd.scan && !hit_r) begin
      found_r <= right_found;
      idx_r   <= right_idx;
    end
  end

  assign elem  = elem_r;
  assign found = found_r;
  assign idx   = idx_r;

endmodule

`default_nettype wire

### rtl/core/indexed_list_engine_core.sv
// Top level of the indexed list engine: request decode, cell row, response register.
// Responses: append, push, insert, pop and delete answer in the cycle after acceptance;
//   search answers once the match wave has walked the cell row to cell 0.
// Throughput: one shift or count request per cycle while responses are taken;
//   no new request is accepted while a search is in progress.
// Reset clears the count, the controller state and the response valid; the
//   element cells are not cleared and are only read below the count.
`default_nettype none

module indexed_list_engine_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  ile_in_if.sink     in_ch,
  ile_out_if.source  out_ch
);
  import ile_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [CW-1:0] FULL_CNT  = CW'(CAPACITY);
  localparam logic [IW-1:0] SCAN_LAST = IW'(CAPACITY - 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t          state_r;
  logic [CW-1:0]   count_r;
  logic [IW-1:0]   scan_cnt_r;
  logic            out_valid_r;
  ile_status_t     out_status_r;
  logic            out_found_r;
  logic [IW-1:0]   out_fpos_r;
  logic [CW-1:0]   out_count_r;

  logic            in_ready;
  logic            in_fire;
  logic            out_free;
  logic            scan_done;
  logic            out_load;
  logic            pos_bad;
  logic            full;
  logic            empty;
  logic [CW-1:0]   count_nxt;
  ile_status_t     status_nxt;
  logic [CW-1:0]   cell_pos;
  ile_cmd_t        cmd;
  ile_cmd_t        cell_cmd;
  logic [DATA_WIDTH-1:0] value_w;

  logic [DATA_WIDTH-1:0] elem_w  [CAPACITY];
  logic                  found_w [CAPACITY];
  logic [IW-1:0]         idx_w   [CAPACITY];

  // Handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_ready && in_ch.valid;
  assign in_ch.ready = in_ready;

  // Response register loads on a shift/count transaction or at the end of a scan
  assign scan_done = (state_r == S_SCAN) && (scan_cnt_r == SCAN_LAST);
  assign out_load  = (in_fire && !cmd.search) || (scan_done && out_free);

  // Request decode
  assign value_w = DATA_WIDTH'(in_ch.value);
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign pos_bad = (32'(in_ch.position) >= 32'(count_r));

  always_comb begin
    cmd        = '0;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    cell_pos   = CW'(in_ch.position);
    case (ile_kind_t'(in_ch.kind))
      K_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          cell_pos  = count_r;
          count_nxt = count_r + 1'b1;
        end
      end
      K_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          cell_pos  = '0;
          count_nxt = count_r + 1'b1;
        end
      end
      K_INSERT: begin
        if (pos_bad) begin
          status_nxt = ST_INDEX;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.ins   = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      K_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      K_DELETE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (pos_bad) begin
          status_nxt = ST_INDEX;
        end else begin
          cmd.del   = 1'b1;
          count_nxt = count_r - 1'b1;
        end
      end
      K_SEARCH: begin
        cmd.search = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Commands reach the cells only on an accepted transaction or during a scan
  always_comb begin
    cell_cmd        = '0;
    cell_cmd.ins    = in_fire && cmd.ins;
    cell_cmd.del    = in_fire && cmd.del;
    cell_cmd.search = in_fire && cmd.search;
    cell_cmd.scan   = (state_r == S_SCAN);
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_elem;
    logic [DATA_WIDTH-1:0] right_elem;
    logic                  right_found;
    logic [IW-1:0]         right_idx;

    if (g == 0) begin : g_first
      assign left_elem = '0;
    end else begin : g_mid
      assign left_elem = elem_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_elem  = '0;
      assign right_found = 1'b0;
      assign right_idx   = '0;
    end else begin : g_inner
      assign right_elem  = elem_w[g+1];
      assign right_found = found_w[g+1];
      assign right_idx   = idx_w[g+1];
    end

    ile_cell #(
      .IDX        (g),
      .CW         (CW),
      .IW         (IW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmd         (cell_cmd),
      .pos         (cell_pos),
      .count       (count_r),
      .value       (value_w),
      .left_elem   (left_elem),
      .right_elem  (right_elem),
      .right_found (right_found),
      .right_idx   (right_idx),
      .elem        (elem_w[g]),
      .found       (found_w[g]),
      .idx         (idx_w[g])
    );
  end

  // Controller state, count and response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (cmd.search) begin
              state_r    <= S_SCAN;
              scan_cnt_r <= '0;
            end else begin
              count_r      <= count_nxt;
              out_status_r <= status_nxt;
              out_found_r  <= 1'b0;
              out_fpos_r   <= '0;
              out_count_r  <= count_nxt;
            end
          end
        end
        S_SCAN: begin
          if (scan_cnt_r != SCAN_LAST) begin
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end else if (out_free) begin
            // wave has reached cell 0: it holds the lowest match
            state_r      <= S_IDLE;
            out_status_r <= ST_OK;
            out_found_r  <= found_w[0];
            out_fpos_r   <= found_w[0] ? idx_w[0] : '0;
            out_count_r  <= count_r;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Response channel
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.found_position = FPOS_W'(out_fpos_r);
  assign out_ch.count          = CNT_W'(out_count_r);

endmodule

`default_nettype wire
